// ===== sv/sgcq_pkg.sv =====
package sgcq_pkg;

    // fixed field widths
    localparam int POS_W = 31;
    localparam int NUM_W = 9;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GROUP,
        ST_QUERY
    } state_t;

    // chain control, one mode per cycle
    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctl_t;

endpackage

// ===== sv/sgcq_cell.sv =====
module sgcq_cell #(
    parameter int IW = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sgcq_pkg::chain_ctl_t       ctl,
    input  logic [sgcq_pkg::POS_W-1:0] new_pos,
    input  logic [IW-1:0]              new_idx,
    input  logic                       left_keep,
    input  logic                       left_valid,
    input  logic [sgcq_pkg::POS_W-1:0] left_pos,
    input  logic [IW-1:0]              left_idx,
    input  logic                       right_valid,
    input  logic [sgcq_pkg::POS_W-1:0] right_pos,
    input  logic [IW-1:0]              right_idx,
    output logic                       keep,
    output logic                       valid,
    output logic [sgcq_pkg::POS_W-1:0] pos,
    output logic [IW-1:0]              idx
);

    logic                       valid_reg, valid_next;
    logic [sgcq_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [IW-1:0]              idx_reg, idx_next;

    // an entry not above the new word stays put, which keeps the sort stable
    assign keep = valid_reg && (pos_reg <= new_pos);

    // insert: keep, take the new word, or move along from the left; shift: take the right entry
    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        if (ctl.shift)
        begin
            valid_next = right_valid;
            pos_next   = right_pos;
            idx_next   = right_idx;
        end
        else if (ctl.insert && !keep)
        begin
            if (left_keep)
            begin
                valid_next = 1'b1;
                pos_next   = new_pos;
                idx_next   = new_idx;
            end
            else
            begin
                valid_next = left_valid;
                pos_next   = left_pos;
                idx_next   = left_idx;
            end
        end
    end

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        idx_reg <= idx_next;
    end

    assign valid = valid_reg;
    assign pos   = pos_reg;
    assign idx   = idx_reg;

endmodule

// ===== sv/sgcq_chain.sv =====
module sgcq_chain #(
    parameter int N  = 256,
    parameter int IW = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sgcq_pkg::chain_ctl_t       ctl,
    input  logic [sgcq_pkg::POS_W-1:0] new_pos,
    input  logic [IW-1:0]              new_idx,
    output logic                       head_valid,
    output logic [sgcq_pkg::POS_W-1:0] head_pos,
    output logic [IW-1:0]              head_idx
);

    logic                       keep_w  [N];
    logic                       valid_w [N];
    logic [sgcq_pkg::POS_W-1:0] pos_w   [N];
    logic [IW-1:0]              idx_w   [N];

    // row of sorting cells, smallest position at the head
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic                       lk, lv, rv;
        logic [sgcq_pkg::POS_W-1:0] lp, rp;
        logic [IW-1:0]              li, ri;

        if (i == 0)
        begin : g_first
            assign lk = 1'b1;
            assign lv = 1'b0;
            assign lp = '0;
            assign li = '0;
        end
        else
        begin : g_mid
            assign lk = keep_w[i-1];
            assign lv = valid_w[i-1];
            assign lp = pos_w[i-1];
            assign li = idx_w[i-1];
        end

        if (i == N-1)
        begin : g_last
            assign rv = 1'b0;
            assign rp = '0;
            assign ri = '0;
        end
        else
        begin : g_inner
            assign rv = valid_w[i+1];
            assign rp = pos_w[i+1];
            assign ri = idx_w[i+1];
        end

        sgcq_cell #(.IW(IW)) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_pos     (new_pos),
            .new_idx     (new_idx),
            .left_keep   (lk),
            .left_valid  (lv),
            .left_pos    (lp),
            .left_idx    (li),
            .right_valid (rv),
            .right_pos   (rp),
            .right_idx   (ri),
            .keep        (keep_w[i]),
            .valid       (valid_w[i]),
            .pos         (pos_w[i]),
            .idx         (idx_w[i])
        );
    end

    assign head_valid = valid_w[0];
    assign head_pos   = pos_w[0];
    assign head_idx   = idx_w[0];

endmodule

// ===== sv/sorted_gap_connectivity_query_top.sv =====
// load word: one per cycle while item_stall is low; the chain inserts it unless full
// closing load word: inserted like the others, then a grouping walk over every point
// (one chain entry per cycle) during which item_stall is high
// query word: the group memory read is registered on acceptance, then the compare loads
// the result register once the output is free; item_stall is high until the result is
// loaded, so no new query is taken while one is in flight or its result word is stalled
// reset clears the point count, the set state, max_gap and the result valid flag;
// the position and group stores are not cleared and need no clearing pass
module sorted_gap_connectivity_query_top #(
    parameter int MAX_POINTS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sgcq_pkg::POS_W-1:0]          cfg_wdata,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                command,
    input  logic [sgcq_pkg::POS_W-1:0]          position,
    input  logic                                load_last,
    input  logic [sgcq_pkg::NUM_W-1:0]          first_point,
    input  logic [sgcq_pkg::NUM_W-1:0]          second_point,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                connected,
    output logic                                out_of_range
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int NW = (CW > sgcq_pkg::NUM_W) ? CW : sgcq_pkg::NUM_W;
    localparam logic [CW-1:0] FULL = CW'(MAX_POINTS);

    sgcq_pkg::state_t state_reg, state_next;

    logic [sgcq_pkg::POS_W-1:0] max_gap_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic                       ready_reg, ready_next;
    logic [CW-1:0]              walk_reg, walk_next;
    logic [IW-1:0]              group_reg, group_next;
    logic [sgcq_pkg::POS_W-1:0] prev_reg;
    logic [IW-1:0]              addr_a_reg, addr_b_reg;
    logic                       qoor_reg;
    logic [IW-1:0]              rd_a_reg, rd_b_reg;
    logic                       result_valid_reg, result_valid_next;
    logic                       connected_reg, connected_next;
    logic                       oor_reg, oor_next;

    logic                       accept, load_acc, query_acc, out_free;
    sgcq_pkg::chain_ctl_t       ctl;
    logic                       head_valid;
    logic [sgcq_pkg::POS_W-1:0] head_pos;
    logic [IW-1:0]              head_idx;
    logic [CW-1:0]              base_count;
    logic [NW-1:0]              num_a, num_b, limit;
    logic                       qoor;
    logic [IW-1:0]              qa, qb, ra, rb;
    logic [sgcq_pkg::POS_W-1:0] gap;
    logic                       new_group;
    logic [IW-1:0]              head_group;
    logic                       walk_done;

    logic [IW-1:0] group_mem [MAX_POINTS];

    assign item_stall = (state_reg != sgcq_pkg::ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign load_acc   = accept && (command == sgcq_pkg::CMD_LOAD);
    assign query_acc  = accept && (command == sgcq_pkg::CMD_QUERY);
    assign out_free   = !result_valid_reg || !result_stall;

    // a load after a closed set starts a new one
    assign base_count = ready_reg ? '0 : count_reg;

    // chain control
    always_comb
    begin
        ctl.insert = load_acc && (base_count < FULL);
        ctl.shift  = (state_reg == sgcq_pkg::ST_GROUP);
    end

    sgcq_chain #(.N(MAX_POINTS), .IW(IW)) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_pos    (position),
        .new_idx    (base_count[IW-1:0]),
        .head_valid (head_valid),
        .head_pos   (head_pos),
        .head_idx   (head_idx)
    );

    // query range check and addresses
    assign limit = ready_reg ? NW'(count_reg) : '0;
    assign num_a = NW'(first_point);
    assign num_b = NW'(second_point);
    assign qoor  = (num_a == '0) || (num_b == '0) || (num_a > limit) || (num_b > limit);
    assign qa    = IW'(num_a - NW'(1));
    assign qb    = IW'(num_b - NW'(1));
    assign ra    = (state_reg == sgcq_pkg::ST_IDLE) ? qa : addr_a_reg;
    assign rb    = (state_reg == sgcq_pkg::ST_IDLE) ? qb : addr_b_reg;

    // grouping walk: head of the chain against the previous position
    assign gap        = head_pos - prev_reg;
    assign new_group  = (walk_reg != '0) && (gap > max_gap_reg);
    assign head_group = (walk_reg == '0) ? '0 : (new_group ? group_reg + IW'(1) : group_reg);
    assign walk_done  = (walk_reg == count_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgcq_pkg::ST_IDLE:
            begin
                if (load_acc && load_last)
                    state_next = sgcq_pkg::ST_GROUP;
                else if (query_acc)
                    state_next = sgcq_pkg::ST_QUERY;
            end
            sgcq_pkg::ST_GROUP:
            begin
                if (walk_done)
                    state_next = sgcq_pkg::ST_IDLE;
            end
            sgcq_pkg::ST_QUERY:
            begin
                if (out_free)
                    state_next = sgcq_pkg::ST_IDLE;
            end
            default: state_next = sgcq_pkg::ST_IDLE;
        endcase
    end

    // datapath and output next values
    always_comb
    begin
        count_next        = count_reg;
        ready_next        = ready_reg;
        walk_next         = walk_reg;
        group_next        = group_reg;
        result_valid_next = result_valid_reg && result_stall;
        connected_next    = connected_reg;
        oor_next          = oor_reg;
        case (state_reg)
            sgcq_pkg::ST_IDLE:
            begin
                if (load_acc)
                begin
                    ready_next = 1'b0;
                    count_next = (base_count < FULL) ? base_count + CW'(1) : base_count;
                    walk_next  = '0;
                end
            end
            sgcq_pkg::ST_GROUP:
            begin
                walk_next  = walk_reg + CW'(1);
                group_next = head_group;
                if (walk_done)
                    ready_next = 1'b1;
            end
            sgcq_pkg::ST_QUERY:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    oor_next          = qoor_reg;
                    connected_next    = !qoor_reg && (rd_a_reg == rd_b_reg);
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sgcq_pkg::ST_IDLE;
            max_gap_reg      <= '0;
            count_reg        <= '0;
            ready_reg        <= 1'b0;
            walk_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            ready_reg        <= ready_next;
            walk_reg         <= walk_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
                max_gap_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        group_reg     <= group_next;
        connected_reg <= connected_next;
        oor_reg       <= oor_next;
        if (state_reg == sgcq_pkg::ST_GROUP)
            prev_reg <= head_pos;
        if (query_acc)
        begin
            addr_a_reg <= qa;
            addr_b_reg <= qb;
            qoor_reg   <= qoor;
        end
    end

    // group memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (state_reg == sgcq_pkg::ST_GROUP)
            group_mem[head_idx] <= head_group;
        rd_a_reg <= group_mem[ra];
        rd_b_reg <= group_mem[rb];
    end

    assign result_valid = result_valid_reg;
    assign connected    = connected_reg;
    assign out_of_range = oor_reg;

    // the walk always finds a point at the head of the chain
    a_walk_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sgcq_pkg::ST_GROUP) |-> head_valid)
        else $error("grouping walk found an empty chain head");

    // a new result word only follows a query
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == sgcq_pkg::ST_QUERY))
        else $error("result word without a query");

    // the set closes only at the end of a walk
    a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(state_reg == sgcq_pkg::ST_GROUP))
        else $error("set closed outside the grouping walk");

    // connected is never reported with out of range
    a_result_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(connected_reg && oor_reg))
        else $error("connected and out of range together");

endmodule
